FILE: sv/scrf_pkg.sv
// ----------------------------------------------------------------------------
// Secant cubic root finder package
// Shared widths, codes, reset values and the types passed between modules.
// ----------------------------------------------------------------------------
package scrf_pkg;

   localparam int FRAC_BITS_DEF  = 32;
   localparam int WORD_WIDTH_DEF = 64;

   // Internal datapath width: wide enough for every term, product and quotient.
   localparam int WIDE_W  = 256;
   localparam int CNT_W   = $clog2(WIDE_W);
   localparam int FIELD_W = 64;
   localparam int COEF_W  = 16;
   localparam int TOL_W   = 32;
   localparam int LIM_W   = 8;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [CSR_AW-1:0] REG_COEF_CUBIC    = 3'd0;
   localparam logic [CSR_AW-1:0] REG_COEF_SQUARE   = 3'd1;
   localparam logic [CSR_AW-1:0] REG_COEF_LINEAR   = 3'd2;
   localparam logic [CSR_AW-1:0] REG_COEF_CONSTANT = 3'd3;
   localparam logic [CSR_AW-1:0] REG_TOLERANCE     = 3'd4;
   localparam logic [CSR_AW-1:0] REG_ITER_LIMIT    = 3'd5;

   localparam logic [COEF_W-1:0] RST_COEF_CUBIC    = 16'sd10;
   localparam logic [COEF_W-1:0] RST_COEF_SQUARE   = -16'sd3;
   localparam logic [COEF_W-1:0] RST_COEF_LINEAR   = -16'sd11;
   localparam logic [COEF_W-1:0] RST_COEF_CONSTANT = -16'sd11;
   localparam logic [TOL_W-1:0]  RST_TOLERANCE     = 32'd43;
   localparam logic [LIM_W-1:0]  RST_ITER_LIMIT    = 8'd100;

   typedef enum logic [1:0] {
      STAT_CONVERGED = 2'd0,
      STAT_LIMIT     = 2'd1,
      STAT_ZERO_DEN  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_HMUL,
      ST_HADD,
      ST_DEN,
      ST_NMUL,
      ST_NEGN,
      ST_NEGD,
      ST_DIV,
      ST_QFIX,
      ST_UPD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_cubic;
      logic signed [COEF_W-1:0] coef_square;
      logic signed [COEF_W-1:0] coef_linear;
      logic signed [COEF_W-1:0] coef_constant;
      logic [TOL_W-1:0]         tolerance;
      logic [LIM_W-1:0]         iteration_limit;
   } cfg_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] root;
      logic [LIM_W-1:0]          step_count;
      status_type                status;
   } result_type;

endpackage

FILE: sv/secant_cubic_root_finder.sv
// Each secant step runs on one shared 256-bit adder: seven serial
// multiplications and a restoring divide; a request whose guesses already
// converge goes straight to the result without them.
// Throughput: one request at a time; req_tready is high only while the engine idles.
// Reset (synchronous, active high) restores the registers to their listed values
// and empties the engine and the result register.
// ----------------------------------------------------------------------------
// Secant cubic root finder
// Stream wrapper: configuration registers, engine and result register.
// ----------------------------------------------------------------------------
module secant_cubic_root_finder #(
   parameter int FRAC_BITS  = scrf_pkg::FRAC_BITS_DEF,
   parameter int WORD_WIDTH = scrf_pkg::WORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [127:0]                  req_tdata,  // guess_first, guess_second
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [71:0]                   rsp_tdata,  // root, step_count
   output logic [1:0]                    rsp_tuser,  // status
   input  logic                          csr_we,
   input  logic [scrf_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [scrf_pkg::CSR_DW-1:0]   csr_wdata
);

   scrf_pkg::cfg_type    cfg_ff;
   scrf_pkg::result_type res, rsp_ff;
   logic                 rsp_valid_ff, eng_idle, res_valid, res_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_cubic      <= scrf_pkg::RST_COEF_CUBIC;
         cfg_ff.coef_square     <= scrf_pkg::RST_COEF_SQUARE;
         cfg_ff.coef_linear     <= scrf_pkg::RST_COEF_LINEAR;
         cfg_ff.coef_constant   <= scrf_pkg::RST_COEF_CONSTANT;
         cfg_ff.tolerance       <= scrf_pkg::RST_TOLERANCE;
         cfg_ff.iteration_limit <= scrf_pkg::RST_ITER_LIMIT;
      end else if (csr_we) begin
         case (csr_addr)
            scrf_pkg::REG_COEF_CUBIC:    cfg_ff.coef_cubic    <= csr_wdata[15:0];
            scrf_pkg::REG_COEF_SQUARE:   cfg_ff.coef_square   <= csr_wdata[15:0];
            scrf_pkg::REG_COEF_LINEAR:   cfg_ff.coef_linear   <= csr_wdata[15:0];
            scrf_pkg::REG_COEF_CONSTANT: cfg_ff.coef_constant <= csr_wdata[15:0];
            scrf_pkg::REG_TOLERANCE:     cfg_ff.tolerance     <= csr_wdata;
            scrf_pkg::REG_ITER_LIMIT:    cfg_ff.iteration_limit <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // The engine hands its result over once the result register is free.
   assign res_take   = res_valid && (!rsp_valid_ff || rsp_tready);
   assign req_tready = eng_idle;

   scrf_engine #(
      .FRAC_BITS  (FRAC_BITS),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (req_tvalid && req_tready),
      .guess_first  (req_tdata[63:0]),
      .guess_second (req_tdata[127:64]),
      .cfg          (cfg_ff),
      .idle         (eng_idle),
      .res_valid    (res_valid),
      .res_ready    (res_take),
      .res          (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.step_count, rsp_ff.root};
   assign rsp_tuser  = rsp_ff.status;

endmodule

FILE: sv/scrf_engine.sv
// ----------------------------------------------------------------------------
// Secant iteration engine
// Sequencer around one shared wide adder: shift-add multiply, restoring
// divide, negation, saturation and the convergence checks.
// ----------------------------------------------------------------------------
module scrf_engine #(
   parameter int FRAC_BITS  = scrf_pkg::FRAC_BITS_DEF,
   parameter int WORD_WIDTH = scrf_pkg::WORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [scrf_pkg::FIELD_W-1:0]      guess_first,
   input  logic [scrf_pkg::FIELD_W-1:0]      guess_second,
   input  scrf_pkg::cfg_type                 cfg,
   output logic                              idle,
   output logic                              res_valid,
   input  logic                              res_ready,
   output scrf_pkg::result_type              res
);

   localparam int W  = scrf_pkg::WIDE_W;
   localparam int MW = WORD_WIDTH + 1;
   localparam int CW = scrf_pkg::CNT_W;
   localparam int LW = scrf_pkg::LIM_W;

   scrf_pkg::state_type state_ff, state_in;
   scrf_pkg::status_type status_ff, status_in;
   logic signed [WORD_WIDTH-1:0] x1_ff, x1_in, x2_ff, x2_in;
   logic [MW-1:0] dif_ff, dif_in, mplier_ff, mplier_in;
   logic [W-1:0]  mcand_ff, mcand_in, prod_ff, prod_in, f1_ff, f1_in;
   logic [W-1:0]  den_ff, den_in, rem_ff, rem_in, quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    hs_ff, hs_in;
   logic          ps_ff, ps_in, qneg_ff, qneg_in;
   logic [LW-1:0] steps_ff, steps_in;

   logic [W-1:0]  add_a, add_b, add_res;
   logic          add_sub;
   logic [MW-1:0] dif, absd;
   logic [LW-1:0] lim, steps_inc;
   logic [W-1:0]  term, fval, rem_sh, xw;
   logic          in_range;

   // The one shared wide adder/subtractor.
   assign add_res = add_a + (add_b ^ {W{add_sub}}) + W'(add_sub);

   assign idle      = (state_ff == scrf_pkg::ST_IDLE);
   assign res_valid = (state_ff == scrf_pkg::ST_DONE);
   assign res.root       = scrf_pkg::FIELD_W'(x2_ff);
   assign res.step_count = steps_ff;
   assign res.status     = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scrf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      status_ff <= status_in;
      x1_ff     <= x1_in;
      x2_ff     <= x2_in;
      dif_ff    <= dif_in;
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      prod_ff   <= prod_in;
      f1_ff     <= f1_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      hs_ff     <= hs_in;
      ps_ff     <= ps_in;
      qneg_ff   <= qneg_in;
      steps_ff  <= steps_in;
   end

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      x1_in     = x1_ff;
      x2_in     = x2_ff;
      dif_in    = dif_ff;
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      prod_in   = prod_ff;
      f1_in     = f1_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      hs_in     = hs_ff;
      ps_in     = ps_ff;
      qneg_in   = qneg_ff;
      steps_in  = steps_ff;
      add_a     = prod_ff;
      add_b     = mcand_ff;
      add_sub   = 1'b0;

      dif  = MW'(x1_ff) - MW'(x2_ff);
      absd = dif[MW-1] ? (~dif + MW'(1)) : dif;
      lim  = (cfg.iteration_limit == '0) ? LW'(1) : cfg.iteration_limit;
      steps_inc = steps_ff + LW'(1);
      rem_sh = {rem_ff[W-2:0], prod_ff[W-1]};
      xw     = W'(x1_ff);

      case (hs_ff)
         2'd0:    term = W'(cfg.coef_square) << FRAC_BITS;
         2'd1:    term = W'(cfg.coef_linear) << (2 * FRAC_BITS);
         default: term = W'(cfg.coef_constant) << (3 * FRAC_BITS);
      endcase
      fval = W'($signed(add_res) >>> (2 * FRAC_BITS));
      in_range = (&add_res[W-1:WORD_WIDTH-1]) | ~(|add_res[W-1:WORD_WIDTH-1]);

      case (state_ff)
         scrf_pkg::ST_IDLE: begin
            if (start) begin
               x1_in    = guess_first[WORD_WIDTH-1:0];
               x2_in    = guess_second[WORD_WIDTH-1:0];
               steps_in = '0;
               state_in = scrf_pkg::ST_CHECK;
            end
         end
         scrf_pkg::ST_CHECK: begin
            steps_in = steps_inc;
            if (absd <= MW'(cfg.tolerance)) begin
               status_in = scrf_pkg::STAT_CONVERGED;
               state_in  = scrf_pkg::ST_DONE;
            end else if (steps_inc >= lim) begin
               status_in = scrf_pkg::STAT_LIMIT;
               state_in  = scrf_pkg::ST_DONE;
            end else begin
               // f(x1) by Horner's rule, exact with three times the fraction bits.
               dif_in    = dif;
               ps_in     = 1'b0;
               hs_in     = 2'd0;
               mcand_in  = W'(cfg.coef_cubic);
               prod_in   = '0;
               mplier_in = MW'(x1_ff);
               cnt_in    = '0;
               state_in  = scrf_pkg::ST_HMUL;
            end
         end
         scrf_pkg::ST_HMUL, scrf_pkg::ST_NMUL: begin
            // The top multiplier bit carries negative weight.
            add_sub  = (cnt_ff == CW'(MW - 1));
            if (mplier_ff[0]) begin
               prod_in = add_res;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = {mplier_ff[MW-1], mplier_ff[MW-1:1]};
            cnt_in    = cnt_ff + CW'(1);
            if (cnt_ff == CW'(MW - 1)) begin
               state_in = (state_ff == scrf_pkg::ST_HMUL) ? scrf_pkg::ST_HADD
                                                          : scrf_pkg::ST_NEGN;
            end
         end
         scrf_pkg::ST_HADD: begin
            add_b = term;
            if (hs_ff != 2'd2) begin
               hs_in     = hs_ff + 2'd1;
               mcand_in  = add_res;
               prod_in   = '0;
               mplier_in = ps_ff ? MW'(x2_ff) : MW'(x1_ff);
               cnt_in    = '0;
               state_in  = scrf_pkg::ST_HMUL;
            end else if (!ps_ff) begin
               f1_in     = fval;
               ps_in     = 1'b1;
               hs_in     = 2'd0;
               mcand_in  = W'(cfg.coef_cubic);
               prod_in   = '0;
               mplier_in = MW'(x2_ff);
               cnt_in    = '0;
               state_in  = scrf_pkg::ST_HMUL;
            end else begin
               prod_in  = fval;
               state_in = scrf_pkg::ST_DEN;
            end
         end
         scrf_pkg::ST_DEN: begin
            add_a   = f1_ff;
            add_b   = prod_ff;
            add_sub = 1'b1;
            den_in  = add_res;
            if (add_res == '0) begin
               status_in = scrf_pkg::STAT_ZERO_DEN;
               state_in  = scrf_pkg::ST_DONE;
            end else begin
               mcand_in  = f1_ff;
               prod_in   = '0;
               mplier_in = dif_ff;
               cnt_in    = '0;
               state_in  = scrf_pkg::ST_NMUL;
            end
         end
         scrf_pkg::ST_NEGN: begin
            add_a   = '0;
            add_b   = prod_ff;
            add_sub = 1'b1;
            qneg_in = prod_ff[W-1] ^ den_ff[W-1];
            if (prod_ff[W-1]) begin
               prod_in = add_res;
            end
            state_in = scrf_pkg::ST_NEGD;
         end
         scrf_pkg::ST_NEGD: begin
            add_a   = '0;
            add_b   = den_ff;
            add_sub = 1'b1;
            if (den_ff[W-1]) begin
               den_in = add_res;
            end
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = scrf_pkg::ST_DIV;
         end
         scrf_pkg::ST_DIV: begin
            // Restoring division, one quotient bit per cycle, numerator in prod.
            add_a   = rem_sh;
            add_b   = den_ff;
            add_sub = 1'b1;
            if (!add_res[W-1]) begin
               rem_in = add_res;
               quo_in = {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[W-2:0], 1'b0};
            end
            prod_in = prod_ff << 1;
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(W - 1)) begin
               state_in = scrf_pkg::ST_QFIX;
            end
         end
         scrf_pkg::ST_QFIX: begin
            add_a   = '0;
            add_b   = quo_ff;
            add_sub = 1'b1;
            if (qneg_ff) begin
               quo_in = add_res;
            end
            state_in = scrf_pkg::ST_UPD;
         end
         scrf_pkg::ST_UPD: begin
            add_a   = xw;
            add_b   = quo_ff;
            add_sub = 1'b1;
            x1_in   = x2_ff;
            if (in_range) begin
               x2_in = add_res[WORD_WIDTH-1:0];
            end else begin
               x2_in = {add_res[W-1], {(WORD_WIDTH-1){~add_res[W-1]}}};
            end
            state_in = scrf_pkg::ST_CHECK;
         end
         scrf_pkg::ST_DONE: begin
            if (res_ready) begin
               state_in = scrf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scrf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/scrf_checker.sv
// ----------------------------------------------------------------------------
// Secant cubic root finder checker
// Port-level properties of the root finder, bound to the top level.
// ----------------------------------------------------------------------------
module scrf_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [71:0]  rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // One request at a time: the block is busy right after taking one.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // At least one convergence check precedes every result.
   a_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:64] != 8'd0)
      else $error("result with zero step count");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("undefined status code");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind secant_cubic_root_finder scrf_checker u_scrf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/secant_cubic_root_finder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Secant cubic root finder checker
// Watches the request, result and register ports. Keeps its own copy of the
// registers, predicts each result exactly at 256-bit precision and compares
// every result with the oldest prediction.
// ----------------------------------------------------------------------------
module secant_cubic_root_finder_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [127:0]                  req_tdata,  // guess_first, guess_second
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [71:0]                   rsp_tdata,  // root, step_count
   input  logic [1:0]                    rsp_tuser,  // status
   input  logic                          csr_we,
   input  logic [scrf_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [scrf_pkg::CSR_DW-1:0]   csr_wdata,
   output int                            fail_count,
   output int                            pending
);

   localparam logic signed [scrf_pkg::WIDE_W-1:0] ROOT_MAX =
      $signed({193'd0, {63{1'b1}}});
   localparam logic signed [scrf_pkg::WIDE_W-1:0] ROOT_MIN = -ROOT_MAX - 1;

   logic signed [scrf_pkg::COEF_W-1:0] cubic_q, square_q, linear_q, constant_q;
   logic [scrf_pkg::TOL_W-1:0]         tol_q;
   logic [scrf_pkg::LIM_W-1:0]         limit_q;
   scrf_pkg::result_type               expected_roots[$];

   function automatic logic signed [scrf_pkg::WIDE_W-1:0] cubic_value(
      input logic signed [scrf_pkg::WIDE_W-1:0] x);
      logic signed [scrf_pkg::WIDE_W-1:0] c3, c2, c1, c0, acc;
      c3 = cubic_q;
      c2 = square_q;
      c1 = linear_q;
      c0 = constant_q;
      acc = c3 * x * x * x + ((c2 * x * x) <<< scrf_pkg::FRAC_BITS_DEF)
          + ((c1 * x) <<< (2 * scrf_pkg::FRAC_BITS_DEF))
          + (c0 <<< (3 * scrf_pkg::FRAC_BITS_DEF));
      return acc >>> (2 * scrf_pkg::FRAC_BITS_DEF);
   endfunction

   function automatic scrf_pkg::result_type find_root(input logic [63:0] g1,
                                                       input logic [63:0] g2);
      logic signed [scrf_pkg::WIDE_W-1:0] x1, x2, gap, f1, f2, den, num, quo, nx, bound;
      int                   steps;
      int                   lim;
      scrf_pkg::result_type r;
      x1 = $signed(g1);
      x2 = $signed(g2);
      bound = $signed({224'd0, tol_q});
      lim = (limit_q == 0) ? 1 : int'(limit_q);
      steps = 0;
      while (1) begin
         steps++;
         gap = x2 - x1;
         if (gap < 0) gap = -gap;
         if (gap <= bound) begin
            r.status = scrf_pkg::STAT_CONVERGED;
            break;
         end
         if (steps >= lim) begin
            r.status = scrf_pkg::STAT_LIMIT;
            break;
         end
         f1 = cubic_value(x1);
         f2 = cubic_value(x2);
         den = f1 - f2;
         if (den == 0) begin
            r.status = scrf_pkg::STAT_ZERO_DEN;
            break;
         end
         num = f1 * (x1 - x2);
         quo = num / den;
         nx = x1 - quo;
         if (nx > ROOT_MAX) nx = ROOT_MAX;
         else if (nx < ROOT_MIN) nx = ROOT_MIN;
         x1 = x2;
         x2 = nx;
      end
      r.root = x2[63:0];
      r.step_count = steps[7:0];
      return r;
   endfunction

   always @(posedge clock) begin
      scrf_pkg::result_type want, got;
      if (reset) begin
         cubic_q    <= scrf_pkg::RST_COEF_CUBIC;
         square_q   <= scrf_pkg::RST_COEF_SQUARE;
         linear_q   <= scrf_pkg::RST_COEF_LINEAR;
         constant_q <= scrf_pkg::RST_COEF_CONSTANT;
         tol_q      <= scrf_pkg::RST_TOLERANCE;
         limit_q    <= scrf_pkg::RST_ITER_LIMIT;
         expected_roots.delete();
         pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               scrf_pkg::REG_COEF_CUBIC:    cubic_q    <= csr_wdata[scrf_pkg::COEF_W-1:0];
               scrf_pkg::REG_COEF_SQUARE:   square_q   <= csr_wdata[scrf_pkg::COEF_W-1:0];
               scrf_pkg::REG_COEF_LINEAR:   linear_q   <= csr_wdata[scrf_pkg::COEF_W-1:0];
               scrf_pkg::REG_COEF_CONSTANT: constant_q <= csr_wdata[scrf_pkg::COEF_W-1:0];
               scrf_pkg::REG_TOLERANCE:     tol_q      <= csr_wdata[scrf_pkg::TOL_W-1:0];
               scrf_pkg::REG_ITER_LIMIT:    limit_q    <= csr_wdata[scrf_pkg::LIM_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_roots.push_back(find_root(req_tdata[63:0], req_tdata[127:64]));
         if (rsp_tvalid && rsp_tready) begin
            got.root = rsp_tdata[63:0];
            got.step_count = rsp_tdata[71:64];
            got.status = scrf_pkg::status_type'(rsp_tuser);
            if (expected_roots.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result with no request outstanding: %s %h %0d %0d",
                           $time, "root, steps, status", got.root, got.step_count,
                           got.status);
            end else begin
               want = expected_roots.pop_front();
               if (got.root !== want.root || got.step_count !== want.step_count
                   || got.status !== want.status) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch: expected root %h steps %0d status %0d,",
                               " got root %h steps %0d status %0d"},
                              $time, want.root, want.step_count, want.status,
                              got.root, got.step_count, got.status);
               end
            end
         end
         pending <= expected_roots.size();
      end
   end

   initial fail_count = 0;

endmodule

FILE: tb/secant_cubic_root_finder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Secant cubic root finder test
// Drives directed and random guess pairs through several register settings
// with random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module secant_cubic_root_finder_test;

   localparam int QUIET_LIMIT = 1000000;
   localparam logic [63:0] ONE = 64'h1_0000_0000;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [127:0]                  req_tdata;  // guess_first, guess_second
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [71:0]                   rsp_tdata;  // root, step_count
   logic [1:0]                    rsp_tuser;  // status
   logic                          csr_we;
   logic [scrf_pkg::CSR_AW-1:0]   csr_addr;
   logic [scrf_pkg::CSR_DW-1:0]   csr_wdata;
   int                            fail_count;
   int                            pending;
   int                            tx_idle;
   int                            rx_idle;
   int                            hold_cycles;
   int                            quiet;

   secant_cubic_root_finder DUT (.*);

   secant_cubic_root_finder_checker checker_i (.*);

   always #6 clock = ~clock;

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready = 1'b0;
         hold_cycles--;
      end else begin
         rsp_tready = ($urandom_range(99) >= rx_idle);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_guesses(input logic [63:0] g1, input logic [63:0] g2);
      if ($urandom_range(99) < tx_idle) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tdata = {g2, g1};
      req_tvalid = 1'b1;
      #1;
      while (!req_tready) begin
         @(negedge clock);
         #1;
      end
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [scrf_pkg::CSR_AW-1:0] idx,
                            input logic [scrf_pkg::CSR_DW-1:0] val);
      req_tvalid = 1'b0;
      wait (pending == 0);
      repeat (8) @(negedge clock);
      csr_addr = idx;
      csr_wdata = val;
      csr_we = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // A guess with a small integer part, where the cubics usually have their roots.
   function automatic logic [63:0] near_guess();
      logic [31:0] whole;
      whole = $urandom_range(6) - 3;
      return {whole, 32'($urandom)};
   endfunction

   function automatic logic [63:0] any_guess();
      case ($urandom_range(3))
         0: return {$urandom, $urandom};
         default: return near_guess();
      endcase
   endfunction

   task automatic random_settings();
      int k;
      for (k = 0; k < 4; k++)
         write_reg(scrf_pkg::REG_COEF_CUBIC + k[scrf_pkg::CSR_AW-1:0],
                   ($urandom_range(1) != 0) ? $urandom
                                            : 32'($urandom_range(40) - 20));
      case ($urandom_range(3))
         0: write_reg(scrf_pkg::REG_TOLERANCE, 0);
         1: write_reg(scrf_pkg::REG_TOLERANCE, $urandom);
         default: write_reg(scrf_pkg::REG_TOLERANCE, $urandom_range(100000));
      endcase
      write_reg(scrf_pkg::REG_ITER_LIMIT, $urandom_range(4));
   endtask

   task automatic random_items(input int count);
      int n;
      logic [63:0] g1;
      for (n = 0; n < count; n++) begin
         g1 = any_guess();
         case ($urandom_range(4))
            0: send_guesses(g1, g1 + 64'($urandom_range(200)));
            1: send_guesses({$urandom, $urandom}, {$urandom, $urandom});
            default: send_guesses(g1, any_guess());
         endcase
      end
   endtask

   initial begin
      int mode, part;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      tx_idle = 21;
      rx_idle = 70;
      hold_cycles = 0;
      quiet = 0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // Settings after reset: guesses around the real root near 1.5.
      send_guesses(ONE, 2 * ONE);
      send_guesses(2 * ONE, ONE);
      send_guesses(64'd0, 64'd0);
      send_guesses(ONE, ONE + 64'd43);
      send_guesses(ONE, ONE + 64'd44);
      send_guesses(-(ONE + ONE / 2), 3 * ONE);

      // A zero limit acts as one; zero tolerance; extremes of the guesses.
      write_reg(scrf_pkg::REG_TOLERANCE, 0);
      write_reg(scrf_pkg::REG_ITER_LIMIT, 0);
      send_guesses(64'd0, ONE);
      write_reg(scrf_pkg::REG_ITER_LIMIT, 2);
      send_guesses(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
      send_guesses(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
      send_guesses(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
      send_guesses(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);

      // A flat polynomial gives a zero denominator; unused indexes are ignored.
      write_reg(scrf_pkg::REG_COEF_CUBIC, 0);
      write_reg(scrf_pkg::REG_COEF_SQUARE, 0);
      write_reg(scrf_pkg::REG_COEF_LINEAR, 0);
      write_reg(scrf_pkg::REG_COEF_CONSTANT, 0);
      write_reg(scrf_pkg::REG_ITER_LIMIT, 5);
      write_reg(3'd6, 32'hFFFF_FFFF);
      write_reg(3'd7, 32'hFFFF_FFFF);
      send_guesses(64'd0, ONE);

      // Extreme coefficients and the widest tolerance.
      write_reg(scrf_pkg::REG_COEF_CUBIC, 32'h0000_7FFF);
      write_reg(scrf_pkg::REG_COEF_SQUARE, 32'hFFFF_8000);
      write_reg(scrf_pkg::REG_COEF_LINEAR, 32'hFFFF_8000);
      write_reg(scrf_pkg::REG_COEF_CONSTANT, 32'hFFFF_8000);
      write_reg(scrf_pkg::REG_TOLERANCE, 32'hFFFF_FFFF);
      send_guesses(64'd0, ONE);
      send_guesses(64'd0, ONE - 1);
      send_guesses(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);

      // The largest limit on a pair that converges quickly.
      write_reg(scrf_pkg::REG_COEF_CUBIC, scrf_pkg::RST_COEF_CUBIC);
      write_reg(scrf_pkg::REG_COEF_SQUARE, scrf_pkg::RST_COEF_SQUARE);
      write_reg(scrf_pkg::REG_COEF_LINEAR, scrf_pkg::RST_COEF_LINEAR);
      write_reg(scrf_pkg::REG_COEF_CONSTANT, scrf_pkg::RST_COEF_CONSTANT);
      write_reg(scrf_pkg::REG_TOLERANCE, scrf_pkg::RST_TOLERANCE);
      write_reg(scrf_pkg::REG_ITER_LIMIT, 255);
      send_guesses(ONE, 2 * ONE);

      for (mode = 0; mode < 3; mode++) begin
         tx_idle = (mode == 0) ? 21 : (mode == 1) ? 70 : 0;
         rx_idle = (mode == 0) ? 70 : (mode == 1) ? 21 : 0;
         for (part = 0; part < 4; part++) begin
            random_settings();
            if (mode == 2 && part == 0) begin
               // Results are held back while quick requests keep coming, so the
               // input stalls behind a full result register.
               write_reg(scrf_pkg::REG_TOLERANCE, 32'hFFFF_FFFF);
               hold_cycles = 3000;
               random_items(4);
               write_reg(scrf_pkg::REG_TOLERANCE, $urandom);
            end
            random_items(17);
         end
      end

      req_tvalid = 1'b0;
      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
